// File: rtl/pie_pkg.sv
`default_nettype none
package pie_pkg;

   localparam int LIST_DEPTH = 64;
   localparam int WORD_W     = 32;
   localparam int POS_W      = 7;
   localparam int CNT_W      = 7;

   typedef enum logic [2:0] {
      REQ_APPEND = 3'd0,
      REQ_POP    = 3'd1,
      REQ_INSERT = 3'd2,
      REQ_ERASE  = 3'd3,
      REQ_READ   = 3'd4,
      REQ_CLEAR  = 3'd5
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_ERASE  = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic [POS_W-1:0]         pos;
      logic [CNT_W-1:0]         cnt;
      logic signed [WORD_W-1:0] value;
   } cell_ctl_type;

   typedef struct packed {
      status_type               status;
      logic                     is_empty;
      logic [CNT_W-1:0]         count;
      logic signed [WORD_W-1:0] read_value;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/positional_insert_erase_list_top.sv
// A result is registered in the cycle after its request transaction.
// Throughput: one request per cycle while no result stalls; the count register
// decides the next request; insert and erase shift the cells from pos to cnt.
// Reset: synchronous; clears the word count and the result register valid.
// The word cells are not reset; entries at or above the count are never read.
`default_nettype none
module positional_insert_erase_list_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // position[6:0], value[38:7], zero pad
   input  wire logic [2:0]  req_tuser,  // req_type[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata   // read_value[31:0], count[38:32],
                                        // is_empty[39], status[41:40], zero pad
);

   localparam int Depth = pie_pkg::LIST_DEPTH;

   logic signed [pie_pkg::WORD_W-1:0] cell_word [Depth];
   logic signed [pie_pkg::WORD_W-1:0] cell_rd   [Depth];
   logic signed [pie_pkg::WORD_W-1:0] rd_bus;
   pie_pkg::cell_ctl_type             ctl;
   pie_pkg::rsp_type                  rsp;

   genvar gi;
   generate
      for (gi = 0; gi < Depth; gi++) begin : g_cell
         logic signed [pie_pkg::WORD_W-1:0] lower;
         logic signed [pie_pkg::WORD_W-1:0] upper;
         if (gi == 0) begin : g_lo
            assign lower = '0;
         end else begin : g_lo
            assign lower = cell_word[gi-1];
         end
         if (gi == Depth - 1) begin : g_hi
            assign upper = '0;
         end else begin : g_hi
            assign upper = cell_word[gi+1];
         end
         pie_cell #(.Idx(gi)) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .lower_word (lower),
            .upper_word (upper),
            .word       (cell_word[gi]),
            .rd_word    (cell_rd[gi])
         );
      end
   endgenerate

   always_comb begin
      rd_bus = '0;
      for (int i = 0; i < Depth; i++) begin
         rd_bus = rd_bus | cell_rd[i];
      end
   end

   pie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .req_pos   (req_tdata[6:0]),
      .req_value (req_tdata[38:7]),
      .rd_bus    (rd_bus),
      .ctl       (ctl),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {6'd0, rsp};

endmodule
`default_nettype wire

// File: rtl/pie_cell.sv
`default_nettype none
module pie_cell #(
   parameter int Idx = 0
) (
   input  wire logic                              clock,
   input  wire pie_pkg::cell_ctl_type             ctl,
   input  wire logic signed [pie_pkg::WORD_W-1:0] lower_word,
   input  wire logic signed [pie_pkg::WORD_W-1:0] upper_word,
   output logic signed [pie_pkg::WORD_W-1:0]      word,
   output logic signed [pie_pkg::WORD_W-1:0]      rd_word
);

   localparam logic [pie_pkg::POS_W-1:0] IDX      = pie_pkg::POS_W'(Idx);
   localparam logic [pie_pkg::CNT_W-1:0] IDX_NEXT = pie_pkg::CNT_W'(Idx + 1);
   localparam logic [pie_pkg::CNT_W-1:0] IDX_CNT  = pie_pkg::CNT_W'(Idx);

   logic signed [pie_pkg::WORD_W-1:0] word_ff;
   logic signed [pie_pkg::WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      unique case (ctl.op)
         pie_pkg::CELL_INSERT: begin
            if (IDX == ctl.pos) begin
               word_in = ctl.value;
            end else if (IDX > ctl.pos && IDX_CNT <= ctl.cnt) begin
               word_in = lower_word;
            end
         end
         pie_pkg::CELL_ERASE: begin
            if (IDX >= ctl.pos && IDX_NEXT < ctl.cnt) begin
               word_in = upper_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word    = word_ff;
   assign rd_word = (IDX == ctl.pos) ? word_ff : '0;

endmodule
`default_nettype wire

// File: rtl/pie_ctrl.sv
`default_nettype none
module pie_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [2:0]                        req_kind,
   input  wire logic [pie_pkg::POS_W-1:0]         req_pos,
   input  wire logic signed [pie_pkg::WORD_W-1:0] req_value,
   input  wire logic signed [pie_pkg::WORD_W-1:0] rd_bus,
   output pie_pkg::cell_ctl_type                  ctl,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output pie_pkg::rsp_type                       rsp
);

   localparam logic [pie_pkg::CNT_W-1:0] FULL_CNT = pie_pkg::CNT_W'(pie_pkg::LIST_DEPTH);
   localparam logic [pie_pkg::CNT_W-1:0] ONE      = pie_pkg::CNT_W'(1);

   logic [pie_pkg::CNT_W-1:0] cnt_ff;
   logic [pie_pkg::CNT_W-1:0] cnt_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   pie_pkg::rsp_type          rsp_ff;
   pie_pkg::rsp_type          rsp_in;

   logic                      accept;
   logic                      read_ok;
   pie_pkg::cell_op_type      op;
   logic [pie_pkg::POS_W-1:0] op_pos;
   pie_pkg::status_type       status;
   logic [pie_pkg::CNT_W-1:0] cnt_next;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      status   = pie_pkg::ST_OK;
      cnt_next = cnt_ff;
      op       = pie_pkg::CELL_HOLD;
      op_pos   = req_pos;
      read_ok  = 1'b0;
      unique case (pie_pkg::req_kind_type'(req_kind))
         pie_pkg::REQ_APPEND: begin
            if (cnt_ff == FULL_CNT) begin
               status = pie_pkg::ST_FULL;
            end else begin
               op       = pie_pkg::CELL_INSERT;
               op_pos   = cnt_ff;
               cnt_next = cnt_ff + ONE;
            end
         end
         pie_pkg::REQ_POP: begin
            if (cnt_ff == '0) begin
               status = pie_pkg::ST_EMPTY;
            end else begin
               cnt_next = cnt_ff - ONE;
            end
         end
         pie_pkg::REQ_INSERT: begin
            priority if (req_pos > cnt_ff) begin
               status = pie_pkg::ST_RANGE;
            end else if (cnt_ff == FULL_CNT) begin
               status = pie_pkg::ST_FULL;
            end else begin
               op       = pie_pkg::CELL_INSERT;
               cnt_next = cnt_ff + ONE;
            end
         end
         pie_pkg::REQ_ERASE: begin
            priority if (cnt_ff == '0) begin
               status = pie_pkg::ST_EMPTY;
            end else if (req_pos >= cnt_ff) begin
               status = pie_pkg::ST_RANGE;
            end else begin
               op       = pie_pkg::CELL_ERASE;
               cnt_next = cnt_ff - ONE;
            end
         end
         pie_pkg::REQ_READ: begin
            priority if (cnt_ff == '0) begin
               status = pie_pkg::ST_EMPTY;
            end else if (req_pos >= cnt_ff) begin
               status = pie_pkg::ST_RANGE;
            end else begin
               read_ok = 1'b1;
            end
         end
         pie_pkg::REQ_CLEAR: begin
            cnt_next = '0;
         end
         default: begin
            status = pie_pkg::ST_OK;
         end
      endcase
   end

   assign ctl.op    = accept ? op : pie_pkg::CELL_HOLD;
   assign ctl.pos   = op_pos;
   assign ctl.cnt   = cnt_ff;
   assign ctl.value = req_value;

   always_comb begin
      cnt_in       = accept ? cnt_next : cnt_ff;
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
      rsp_in       = rsp_ff;
      if (accept) begin
         rsp_in.status     = status;
         rsp_in.is_empty   = (cnt_next == '0);
         rsp_in.count      = cnt_next;
         rsp_in.read_value = read_ok ? rd_bus : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/pie_checker.sv
`default_nettype none
module pie_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);

   localparam logic [6:0] FULL_CNT = 7'(pie_pkg::LIST_DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("request transaction without a result");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39] == (rsp_tdata[38:32] == 7'd0))
      else $error("empty flag disagrees with count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[41:40] == pie_pkg::ST_FULL |-> rsp_tdata[38:32] == FULL_CNT)
      else $error("full status below capacity");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[41:40] != pie_pkg::ST_OK |-> rsp_tdata[31:0] == 32'd0)
      else $error("read word on failed request");

endmodule

bind positional_insert_erase_list_top pie_checker u_pie_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
